// ===== rtl/bmhq_pkg.sv =====
// Shared definitions for the binary max-heap queue.
// Command and status codes, and the status bundle passed from the sequencer.
// No dependencies.
package bmhq_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_status;

    localparam t_cmd CMD_PUSH   = 2'd0;
    localparam t_cmd CMD_POP    = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic    busy;
        logic    done;
        logic    empty;
        t_status status;
    } t_seq_stat;

endpackage

// ===== rtl/bmhq_ram.sv =====
// Entry storage for the heap: one write port and two read ports.
// Read data is registered. No package dependencies.
module bmhq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/bmhq_seq.sv =====
// Command sequencer for the heap: sift up, sift down and delete scan, one
// memory access step at a time, around its key comparators.
// Depends on bmhq_pkg and bmhq_ram.
module bmhq_seq
    import bmhq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int NODE_WIDTH = 8,
    parameter int KEY_WIDTH  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  t_cmd                             i_cmd,
    input  logic [NODE_WIDTH-1:0]            i_node,
    input  logic [KEY_WIDTH-1:0]             i_key,
    input  logic                             i_out_free,
    output t_seq_stat                        o_stat,
    output logic [NODE_WIDTH-1:0]            o_root_node,
    output logic [KEY_WIDTH-1:0]             o_root_key,
    output logic [$clog2(CAPACITY+1)-1:0]    o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int DW = NODE_WIDTH + KEY_WIDTH;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_RD    = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_DN_RD    = 4'd3;
    localparam logic [3:0] S_DN_CMP   = 4'd4;
    localparam logic [3:0] S_LAST_RD  = 4'd5;
    localparam logic [3:0] S_LAST_LD  = 4'd6;
    localparam logic [3:0] S_SCAN_RD  = 4'd7;
    localparam logic [3:0] S_SCAN_CMP = 4'd8;
    localparam logic [3:0] S_FIN_RD   = 4'd9;
    localparam logic [3:0] S_FIN_OUT  = 4'd10;

    logic [3:0]            r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_scan, n_scan;
    logic [AW-1:0]         r_idx, n_idx;
    logic [NODE_WIDTH-1:0] r_node, n_node;
    logic [DW-1:0]         r_ent, n_ent;
    t_status               r_status, n_status;
    logic                  r_del, n_del;
    logic                  r_moved, n_moved;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DW-1:0]         wdata;
    logic [AW-1:0]         raddr_a;
    logic [AW-1:0]         raddr_b;
    logic [DW-1:0]         rdata_a;
    logic [DW-1:0]         rdata_b;

    logic [AW-1:0]         parent;
    logic [IW-1:0]         left_idx;
    logic [IW-1:0]         right_idx;
    logic [IW-1:0]         cnt_ext;
    logic [KEY_WIDTH-1:0]  ent_key;
    logic [KEY_WIDTH-1:0]  key_a;
    logic [KEY_WIDTH-1:0]  key_b;
    logic [KEY_WIDTH-1:0]  best_key;
    logic                  take_left;
    logic                  take_right;

    bmhq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign parent    = (r_idx - AW'(1)) >> 1;
    assign left_idx  = {1'b0, r_idx, 1'b1};
    assign right_idx = left_idx + IW'(1);
    assign cnt_ext   = IW'(r_cnt);
    assign ent_key   = r_ent[KEY_WIDTH-1:0];
    assign key_a     = rdata_a[KEY_WIDTH-1:0];
    assign key_b     = rdata_b[KEY_WIDTH-1:0];

    // The child comparators: the left child wins only on a strictly larger key,
    // and the right child must beat whichever of the two is ahead.
    assign take_left  = key_a > ent_key;
    assign best_key   = take_left ? key_a : ent_key;
    assign take_right = (right_idx < cnt_ext) && (key_b > best_key);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_scan   = r_scan;
        n_idx    = r_idx;
        n_node   = r_node;
        n_ent    = r_ent;
        n_status = r_status;
        n_del    = r_del;
        n_moved  = r_moved;
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = r_ent;
        raddr_a  = '0;
        raddr_b  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = ST_OK;
                    n_del    = 1'b0;
                    n_moved  = 1'b0;
                    n_node   = i_node;
                    n_state  = S_FIN_RD;
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (r_cnt >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_ent   = {i_node, i_key};
                                n_idx   = r_cnt[AW-1:0];
                                n_cnt   = r_cnt + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        CMD_POP: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt = r_cnt - CW'(1);
                                n_idx = '0;
                                if (r_cnt != CW'(1)) begin
                                    n_state = S_LAST_RD;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            n_status = ST_NOTFOUND;
                            n_scan   = '0;
                            if (r_cnt != '0) begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_UP_RD: begin
                if (r_idx == '0) begin
                    if (r_del && !r_moved) begin
                        n_state = S_DN_RD;
                    end else begin
                        we      = 1'b1;
                        n_state = S_FIN_RD;
                    end
                end else begin
                    raddr_a = parent;
                    n_state = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                raddr_a = parent;
                if (ent_key > key_a) begin
                    we      = 1'b1;
                    wdata   = rdata_a;
                    n_idx   = parent;
                    n_moved = 1'b1;
                    n_state = S_UP_RD;
                end else if (r_del && !r_moved) begin
                    // The moved entry stays put going up, so try going down.
                    n_state = S_DN_RD;
                end else begin
                    we      = 1'b1;
                    n_state = S_FIN_RD;
                end
            end

            S_DN_RD: begin
                if (left_idx >= cnt_ext) begin
                    we      = 1'b1;
                    n_state = S_FIN_RD;
                end else begin
                    raddr_a = left_idx[AW-1:0];
                    raddr_b = right_idx[AW-1:0];
                    n_state = S_DN_CMP;
                end
            end

            S_DN_CMP: begin
                raddr_a = left_idx[AW-1:0];
                raddr_b = right_idx[AW-1:0];
                we      = 1'b1;
                if (take_right) begin
                    wdata   = rdata_b;
                    n_idx   = right_idx[AW-1:0];
                    n_state = S_DN_RD;
                end else if (take_left) begin
                    wdata   = rdata_a;
                    n_idx   = left_idx[AW-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN_RD;
                end
            end

            S_LAST_RD: begin
                raddr_a = r_cnt[AW-1:0];
                n_state = S_LAST_LD;
            end

            S_LAST_LD: begin
                n_ent   = rdata_a;
                n_state = r_del ? S_UP_RD : S_DN_RD;
            end

            S_SCAN_RD: begin
                raddr_a = r_scan[AW-1:0];
                n_state = S_SCAN_CMP;
            end

            S_SCAN_CMP: begin
                raddr_a = r_scan[AW-1:0];
                if (rdata_a[DW-1:KEY_WIDTH] == r_node) begin
                    n_status = ST_OK;
                    n_cnt    = r_cnt - CW'(1);
                    n_idx    = r_scan[AW-1:0];
                    n_del    = 1'b1;
                    // Deleting the last slot needs no refill.
                    n_state  = (r_scan == r_cnt - CW'(1)) ? S_FIN_RD : S_LAST_RD;
                end else begin
                    n_scan  = r_scan + CW'(1);
                    n_state = (r_scan == r_cnt - CW'(1)) ? S_FIN_RD : S_SCAN_RD;
                end
            end

            S_FIN_RD: begin
                n_state = S_FIN_OUT;
            end

            S_FIN_OUT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_idx    <= n_idx;
        r_node   <= n_node;
        r_ent    <= n_ent;
        r_status <= n_status;
        r_del    <= n_del;
        r_moved  <= n_moved;
    end

    always_comb begin
        o_stat.busy   = (r_state != S_IDLE);
        o_stat.done   = (r_state == S_FIN_OUT) && i_out_free;
        o_stat.empty  = (r_cnt == '0);
        o_stat.status = r_status;
        o_root_node   = o_stat.empty ? '0 : rdata_a[DW-1:KEY_WIDTH];
        o_root_key    = o_stat.empty ? '0 : rdata_a[KEY_WIDTH-1:0];
        o_count       = r_cnt;
    end

endmodule

// ===== rtl/binary_max_heap_queue.sv =====
// Binary max-heap priority queue of (node id, key) entries. The sequencer
// makes one access to the entry memory per step: each level of a sift is a
// read step and a compare step, each entry examined by a delete scan is a
// read step and a compare step, and every command ends with a root read.
// The input is not ready while a command is in progress; a finished result
// sits in an output register, so the next command is taken while that result
// still waits. Slots at or above the entry count never affect a result, so
// the memory needs no clearing after reset.
// Depends on bmhq_pkg and bmhq_seq.
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int NODE_WIDTH = 8,
    parameter int KEY_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [NODE_WIDTH-1:0]         i_node_id,
    input  logic [KEY_WIDTH-1:0]          i_key,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [NODE_WIDTH-1:0]         o_max_node,
    output logic [KEY_WIDTH-1:0]          o_max_key,
    output logic                          o_is_empty,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_total,
    output logic [1:0]                    o_status
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_seq_stat             seq_stat;
    logic [NODE_WIDTH-1:0] root_node;
    logic [KEY_WIDTH-1:0]  root_key;
    logic [CW-1:0]         count;
    logic                  out_free;
    logic                  start;

    assign o_in_ready = !seq_stat.busy;
    assign start      = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;

    bmhq_seq #(
        .CAPACITY   (CAPACITY),
        .NODE_WIDTH (NODE_WIDTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (t_cmd'(i_command)),
        .i_node      (i_node_id),
        .i_key       (i_key),
        .i_out_free  (out_free),
        .o_stat      (seq_stat),
        .o_root_node (root_node),
        .o_root_key  (root_key),
        .o_count     (count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (seq_stat.done) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.done) begin
            o_max_node    <= root_node;
            o_max_key     <= root_key;
            o_is_empty    <= seq_stat.empty;
            o_entry_total <= count;
            o_status      <= seq_stat.status;
        end
    end

endmodule

// ===== rtl/bmhq_chk.sv =====
// Port-level checks for the binary max-heap queue, bound to the top level.
// Depends on bmhq_pkg and binary_max_heap_queue.
module bmhq_chk
    import bmhq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int NODE_WIDTH = 8,
    parameter int KEY_WIDTH  = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [NODE_WIDTH-1:0]         o_max_node,
    input logic [KEY_WIDTH-1:0]          o_max_key,
    input logic                          o_is_empty,
    input logic [$clog2(CAPACITY+1)-1:0] o_entry_total,
    input logic [1:0]                    o_status
);

    localparam int CW = $clog2(CAPACITY + 1);

    // An empty heap reports a zero count and a cleared root.
    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_total == '0)) &&
                        (!o_is_empty || (o_max_node == '0 && o_max_key == '0)))
        else $error("empty flag disagrees with count or root");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_total <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A refused push can only come from a full heap, a refused pop from an empty one.
    a_status_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != ST_FULL || o_entry_total == CW'(CAPACITY)) &&
                        (o_status != ST_EMPTY || o_is_empty))
        else $error("status code disagrees with heap fill");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_max_key) && $stable(o_entry_total) && $stable(o_status))
        else $error("result changed before its transfer");

    // Every command keeps the block busy for at least the cycle after its transfer.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready straight after a command transfer");

endmodule

bind binary_max_heap_queue bmhq_chk #(
    .CAPACITY   (CAPACITY),
    .NODE_WIDTH (NODE_WIDTH),
    .KEY_WIDTH  (KEY_WIDTH)
) u_bmhq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_max_node    (o_max_node),
    .o_max_key     (o_max_key),
    .o_is_empty    (o_is_empty),
    .o_entry_total (o_entry_total),
    .o_status      (o_status)
);
